@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: assertion macros for the checker file dfs_checker.sv
// depends on nothing; pulled in with an include by the file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset disables the check
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/dfs_pkg.sv @@
// dfs_pkg: shared types and codes for the depth-first search engine
// depends on nothing; used by the controller, datapath and top level
`default_nettype none

package dfs_pkg;

   // result status codes
   localparam logic [1:0] ST_RECORD    = 2'd0;
   localparam logic [1:0] ST_EDGE_OK   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   // opcodes
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_RUN      = 1'b1;

   // register indexes
   localparam int REG_VERTEX_COUNT = 0;
   localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

   // parent code of a root
   localparam logic signed [4:0] NO_PARENT = -5'sd1;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic edge_op;
      logic run_init;
      logic root_skip;
      logic root_discover;
      logic scan_read;
      logic push;
      logic finish;
      logic pop_load;
      logic out_read;
      logic out_emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op_run;
      logic count_zero;
      logic root_end;
      logic root_seen;
      logic scan_more;
      logic push_ok;
      logic depth_last;
      logic out_last;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/dfs_csr.sv @@
// dfs_csr: apb-style register block holding vertex_count
// depends on dfs_pkg for the reset value
`default_nettype none

module dfs_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [4:0]       vertex_count
);

   logic [4:0] count_ff;
   logic [4:0] count_in;
   logic       wr_en;

   // single register, every address maps onto it
   assign wr_en = psel && penable && pwrite;
   assign count_in = wr_en ? pwdata[4:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= dfs_pkg::VERTEX_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // read back, every paddr value returns the same word
   always_comb begin
      prdata = {27'd0, count_ff};
      if (paddr != 2'd0) begin
         prdata = {27'd0, count_ff};
      end
   end

   assign pready       = 1'b1;
   assign vertex_count = count_ff;

endmodule

`default_nettype wire

@@ rtl/core/dfs_ctrl.sv @@
// dfs_ctrl: state machine sequencing edge loads, the search and record output
// depends on dfs_pkg for the command and status structs
`default_nettype none

module dfs_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire dfs_pkg::sts_type sts,
   output dfs_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE,
      S_INIT,
      S_ROOT,
      S_SCAN,
      S_EVAL,
      S_POP,
      S_OUT_RD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      emit_ff;
   logic      emit_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      emit_in  = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = sts.op_run ? S_INIT : S_EDGE;
            end
         end
         S_EDGE: begin
            cmd.edge_op = 1'b1;
            state_in = S_IDLE;
         end
         S_INIT: begin
            cmd.run_init = 1'b1;
            state_in = sts.count_zero ? S_IDLE : S_ROOT;
         end
         S_ROOT: begin
            if (sts.root_end) begin
               state_in = S_OUT_RD;
            end else if (sts.root_seen) begin
               cmd.root_skip = 1'b1;
            end else begin
               cmd.root_discover = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_more) begin
               cmd.scan_read = 1'b1;
               state_in = S_EVAL;
            end else begin
               cmd.finish = 1'b1;
               state_in = sts.depth_last ? S_ROOT : S_POP;
            end
         end
         S_EVAL: begin
            cmd.push = sts.push_ok;
            state_in = S_SCAN;
         end
         S_POP: begin
            cmd.pop_load = 1'b1;
            state_in = S_SCAN;
         end
         S_OUT_RD: begin
            if (emit_ff) begin
               cmd.out_emit = 1'b1;
               state_in = sts.out_last ? S_IDLE : S_OUT_RD;
            end else begin
               cmd.out_read = 1'b1;
               emit_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered phase flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/dfs_dpath.sv @@
// dfs_dpath: edge tables, stack, vertex stores and result registers
// depends on dfs_pkg for codes and the command and status structs
`default_nettype none

module dfs_dpath #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [4:0]       vertex_count,
   input  wire logic             req_opcode,
   input  wire logic [3:0]       req_edge_from,
   input  wire logic [3:0]       req_edge_to,
   input  wire dfs_pkg::cmd_type cmd,
   output dfs_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_vertex,
   output logic signed [4:0]     rsp_parent_vertex,
   output logic [5:0]            rsp_discovery_time,
   output logic [5:0]            rsp_finish_time,
   output logic                  rsp_last
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int RW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_EDGES);
   localparam int EW = $clog2(MAX_EDGES + 1);

   // captured request
   logic          op_ff;
   logic [3:0]    from_ff;
   logic [3:0]    to_ff;

   // edge store
   logic [3:0]    esrc_mem [MAX_EDGES];
   logic [3:0]    edst_mem [MAX_EDGES];
   logic [3:0]    esrc_rd_ff;
   logic [3:0]    edst_rd_ff;
   logic [EW-1:0] edges_ff;
   logic [EW-1:0] edges_in;

   // walk state
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [MAX_VERTICES-1:0] visited_in;
   logic [5:0]    stamp_ff;
   logic [5:0]    stamp_in;
   logic [RW-1:0] root_ff;
   logic [RW-1:0] root_in;
   logic [RW-1:0] depth_ff;
   logic [RW-1:0] depth_in;
   logic [RW-1:0] oidx_ff;
   logic [RW-1:0] oidx_in;
   logic [VW-1:0] top_ff;
   logic [EW-1:0] scan_ff;

   // stack store
   logic [VW-1:0] stk_node_mem [MAX_VERTICES];
   logic [EW-1:0] stk_scan_mem [MAX_VERTICES];
   logic [VW-1:0] pop_node_ff;
   logic [EW-1:0] pop_scan_ff;

   // per-vertex stores
   logic signed [4:0] par_mem [MAX_VERTICES];
   logic [5:0]    dis_mem [MAX_VERTICES];
   logic [5:0]    fin_mem [MAX_VERTICES];
   logic signed [4:0] par_rd_ff;
   logic [5:0]    dis_rd_ff;
   logic [5:0]    fin_rd_ff;

   // result registers
   logic          strobe_ff;
   logic          strobe_in;
   logic [1:0]    status_ff;
   logic [3:0]    vertex_ff;
   logic signed [4:0] parent_ff;
   logic [5:0]    disc_ff;
   logic [5:0]    fin_ff;
   logic          last_ff;

   logic [RW-1:0] count;
   logic [VW-1:0] root_idx;
   logic [VW-1:0] dst_idx;
   logic [1:0]    edge_status;
   logic          disc_we;
   logic [VW-1:0] disc_idx;
   logic signed [4:0] disc_par;
   logic [5:0]    stamp_nx;

   // effective vertex count, clamped to the store depth
   always_comb begin
      if (32'(vertex_count) > MAX_VERTICES) begin
         count = RW'(MAX_VERTICES);
      end else begin
         count = RW'(vertex_count);
      end
   end

   assign root_idx = root_ff[VW-1:0];
   assign dst_idx  = VW'(edst_rd_ff);
   assign stamp_nx = stamp_ff + 6'd1;

   // edge insertion outcome
   always_comb begin
      if ((32'(from_ff) >= 32'(count)) || (32'(to_ff) >= 32'(count))) begin
         edge_status = dfs_pkg::ST_RANGE;
      end else if (32'(edges_ff) >= MAX_EDGES) begin
         edge_status = dfs_pkg::ST_FULL;
      end else begin
         edge_status = dfs_pkg::ST_EDGE_OK;
      end
   end

   // status to the controller
   always_comb begin
      sts.op_run     = (req_opcode == dfs_pkg::OP_RUN);
      sts.count_zero = (count == '0);
      sts.root_end   = (root_ff == count);
      sts.root_seen  = visited_ff[root_idx];
      sts.scan_more  = (scan_ff < edges_ff);
      sts.push_ok    = (32'(esrc_rd_ff) == 32'(top_ff))
                    && (32'(edst_rd_ff) < 32'(count))
                    && !visited_ff[dst_idx]
                    && (32'(depth_ff) < MAX_VERTICES);
      sts.depth_last = (depth_ff == RW'(1));
      sts.out_last   = ((32'(oidx_ff) + 1) == 32'(count));
   end

   // discovery write port, shared by roots and pushes
   always_comb begin
      disc_we  = cmd.root_discover || cmd.push;
      disc_idx = cmd.push ? dst_idx : root_idx;
      disc_par = cmd.push ? 5'(top_ff) : dfs_pkg::NO_PARENT;
   end

   // next values of control registers
   always_comb begin
      edges_in   = edges_ff;
      visited_in = visited_ff;
      stamp_in   = stamp_ff;
      root_in    = root_ff;
      depth_in   = depth_ff;
      oidx_in    = oidx_ff;
      strobe_in  = cmd.edge_op || cmd.out_emit;
      if (cmd.edge_op && (edge_status == dfs_pkg::ST_EDGE_OK)) begin
         edges_in = edges_ff + EW'(1);
      end
      if (cmd.run_init) begin
         visited_in = '0;
         stamp_in   = '0;
         root_in    = '0;
         oidx_in    = '0;
      end
      if (cmd.root_skip) begin
         root_in = root_ff + RW'(1);
      end
      if (disc_we) begin
         visited_in[disc_idx] = 1'b1;
         stamp_in = stamp_nx;
      end
      if (cmd.root_discover) begin
         depth_in = RW'(1);
      end
      if (cmd.push) begin
         depth_in = depth_ff + RW'(1);
      end
      if (cmd.finish) begin
         stamp_in = stamp_nx;
         depth_in = depth_ff - RW'(1);
      end
      if (cmd.out_emit) begin
         oidx_in = oidx_ff + RW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff   <= '0;
         visited_ff <= '0;
         stamp_ff   <= '0;
         root_ff    <= '0;
         depth_ff   <= '0;
         oidx_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         edges_ff   <= edges_in;
         visited_ff <= visited_in;
         stamp_ff   <= stamp_in;
         root_ff    <= root_in;
         depth_ff   <= depth_in;
         oidx_ff    <= oidx_in;
         strobe_ff  <= strobe_in;
      end
   end

   // request capture and walk pointers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         from_ff <= req_edge_from;
         to_ff   <= req_edge_to;
      end
      if (cmd.root_discover) begin
         top_ff  <= root_idx;
         scan_ff <= '0;
      end
      if (cmd.scan_read) begin
         scan_ff <= scan_ff + EW'(1);
      end
      if (cmd.push) begin
         top_ff  <= dst_idx;
         scan_ff <= '0;
      end
      if (cmd.pop_load) begin
         top_ff  <= pop_node_ff;
         scan_ff <= pop_scan_ff;
      end
   end

   // edge memory
   always_ff @(posedge clock) begin
      if (cmd.edge_op && (edge_status == dfs_pkg::ST_EDGE_OK)) begin
         esrc_mem[edges_ff[AW-1:0]] <= from_ff;
         edst_mem[edges_ff[AW-1:0]] <= to_ff;
      end
      if (cmd.scan_read) begin
         esrc_rd_ff <= esrc_mem[scan_ff[AW-1:0]];
         edst_rd_ff <= edst_mem[scan_ff[AW-1:0]];
      end
   end

   // stack memory, the top entry lives in top_ff and scan_ff
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_node_mem[VW'(depth_ff - RW'(1))] <= top_ff;
         stk_scan_mem[VW'(depth_ff - RW'(1))] <= scan_ff;
      end
      if (cmd.finish) begin
         pop_node_ff <= stk_node_mem[VW'(depth_ff - RW'(2))];
         pop_scan_ff <= stk_scan_mem[VW'(depth_ff - RW'(2))];
      end
   end

   // per-vertex memories
   always_ff @(posedge clock) begin
      if (disc_we) begin
         par_mem[disc_idx] <= disc_par;
         dis_mem[disc_idx] <= stamp_nx;
      end
      if (cmd.finish) begin
         fin_mem[top_ff] <= stamp_nx;
      end
      if (cmd.out_read) begin
         par_rd_ff <= par_mem[oidx_ff[VW-1:0]];
         dis_rd_ff <= dis_mem[oidx_ff[VW-1:0]];
         fin_rd_ff <= fin_mem[oidx_ff[VW-1:0]];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.edge_op) begin
         status_ff <= edge_status;
         vertex_ff <= 4'd0;
         parent_ff <= 5'sd0;
         disc_ff   <= 6'd0;
         fin_ff    <= 6'd0;
         last_ff   <= (op_ff == dfs_pkg::OP_ADD_EDGE);
      end
      if (cmd.out_emit) begin
         status_ff <= dfs_pkg::ST_RECORD;
         vertex_ff <= 4'(oidx_ff);
         parent_ff <= par_rd_ff;
         disc_ff   <= dis_rd_ff;
         fin_ff    <= fin_rd_ff;
         last_ff   <= sts.out_last;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_vertex         = vertex_ff;
   assign rsp_parent_vertex  = parent_ff;
   assign rsp_discovery_time = disc_ff;
   assign rsp_finish_time    = fin_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/dfs_timestamp_engine.sv @@
// channel   | ports                               | handshake
// request   | req_opcode, req_edge_from/to        | start && !busy
// result    | rsp_status .. rsp_last              | rsp_strobe, one cycle
// config    | psel penable pwrite paddr pwdata    | psel && penable && pwrite
//
// an edge beat holds busy high only in S_EDGE; its result strobe is registered from S_EDGE
// a run walks the vertices below the count over the stored edges:
// each vertex scans the edge memory once, one edge per S_SCAN/S_EVAL pair, resuming after a return
// records leave through S_OUT_RD, each read from the per-vertex memories and then emitted
// reset is synchronous, clears control state and sets vertex_count to 16
// the receiver cannot stall; results are never held
// depends on dfs_pkg, dfs_csr, dfs_ctrl and dfs_dpath
`default_nettype none

module dfs_timestamp_engine #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [3:0]  req_edge_from,
   input  wire logic [3:0]  req_edge_to,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_vertex,
   output logic signed [4:0] rsp_parent_vertex,
   output logic [5:0]       rsp_discovery_time,
   output logic [5:0]       rsp_finish_time,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [4:0]       vertex_count;
   dfs_pkg::cmd_type cmd;
   dfs_pkg::sts_type sts;

   // register block
   dfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .vertex_count (vertex_count)
   );

   // controller
   dfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath
   dfs_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .vertex_count       (vertex_count),
      .req_opcode         (req_opcode),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_vertex         (rsp_vertex),
      .rsp_parent_vertex  (rsp_parent_vertex),
      .rsp_discovery_time (rsp_discovery_time),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

@@ rtl/core/dfs_checker.sv @@
// dfs_checker: port-level checks on the engine, bound to the top level
// depends on assert_macros.svh, dfs_pkg and the top level's ports
`default_nettype none
`include "assert_macros.svh"

module dfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);

   logic edge_beat;

   // a result beat that answers an edge load
   assign edge_beat = rsp_strobe && (rsp_status != dfs_pkg::ST_RECORD);

   // an accepted beat always occupies the engine the next cycle
   `CHK_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // an edge result is the only result of its beat
   `CHK_SAME(a_edge_last, clock, reset, edge_beat, rsp_last, "edge result not last")

   // results never come in adjacent cycles
   `CHK_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back results")

endmodule

bind dfs_timestamp_engine dfs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for dfs_timestamp_engine, edge loads and search runs
// depends on dfs_pkg and the dfs_timestamp_engine rtl; predicts every record in-line
`timescale 1ns / 100ps

module tb;

   localparam int VMAX        = 16;
   localparam int EMAX        = 64;
   localparam int STALL_LIMIT = 20000;

   typedef enum logic [1:0] {C_WHITE, C_GREY, C_BLACK} colour_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        vertex;
      logic signed [4:0] parent;
      logic [5:0]        disc;
      logic [5:0]        fin;
      logic              last;
   } record_type;

   // predictor of the search engine plus the queue of expected beats
   class search_scoreboard;
      int          errors;
      int          checked;
      int          vcount;
      logic [3:0]  src_tab[EMAX];
      logic [3:0]  dst_tab[EMAX];
      int          stored;
      colour_type  colour[VMAX];
      int          parent[VMAX];
      int          disc[VMAX];
      int          fin[VMAX];
      int          stamp;
      int          stk_node[VMAX];
      int          stk_scan[VMAX];
      record_type  expected_beats[$];

      function new();
         vcount = 16;
         stored = 0;
         stamp  = 0;
         errors = 0;
         checked = 0;
         for (int i = 0; i < VMAX; i++) begin
            colour[i] = C_WHITE;
            parent[i] = -1;
            disc[i]   = 0;
            fin[i]    = 0;
         end
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function int live_count();
         return (vcount > VMAX) ? VMAX : vcount;
      endfunction

      function void walk_from(int root, int cnt);
         int      depth;
         int      u;
         int      k;
         int      v;
         bit      pushed;
         colour[root] = C_GREY;
         stamp++;
         disc[root] = stamp;
         stk_node[0] = root;
         stk_scan[0] = 0;
         depth = 1;
         while (depth > 0) begin
            u = stk_node[depth-1];
            pushed = 0;
            while (!pushed && stk_scan[depth-1] < stored) begin
               k = stk_scan[depth-1];
               stk_scan[depth-1]++;
               v = int'(dst_tab[k]);
               // edges from other vertices or to vertices past the count are skipped
               if (int'(src_tab[k]) == u && v < cnt && colour[v] == C_WHITE
                   && depth < VMAX) begin
                  parent[v] = u;
                  colour[v] = C_GREY;
                  stamp++;
                  disc[v] = stamp;
                  stk_node[depth] = v;
                  stk_scan[depth] = 0;
                  depth++;
                  pushed = 1;
               end
            end
            if (!pushed) begin
               colour[u] = C_BLACK;
               stamp++;
               fin[u] = stamp;
               depth--;
            end
         end
      endfunction

      function void note_item(logic op, logic [3:0] from, logic [3:0] to);
         int         cnt;
         record_type r;
         cnt = live_count();
         if (op == dfs_pkg::OP_ADD_EDGE) begin
            r = '0;
            r.last = 1'b1;
            // range check wins over the full check
            if (int'(from) >= cnt || int'(to) >= cnt) r.status = dfs_pkg::ST_RANGE;
            else if (stored >= EMAX) r.status = dfs_pkg::ST_FULL;
            else begin
               src_tab[stored] = from;
               dst_tab[stored] = to;
               stored++;
               r.status = dfs_pkg::ST_EDGE_OK;
            end
            expected_beats = {expected_beats, r};
         end else begin
            for (int i = 0; i < cnt; i++) begin
               colour[i] = C_WHITE;
               parent[i] = -1;
            end
            stamp = 0;
            for (int i = 0; i < cnt; i++)
               if (colour[i] == C_WHITE) walk_from(i, cnt);
            for (int i = 0; i < cnt; i++) begin
               r.status = dfs_pkg::ST_RECORD;
               r.vertex = 4'(i);
               r.parent = 5'(parent[i]);
               r.disc   = 6'(disc[i]);
               r.fin    = 6'(fin[i]);
               r.last   = (i + 1 == cnt);
               expected_beats = {expected_beats, r};
            end
         end
      endfunction

      task check_result(record_type got);
         record_type want;
         checked++;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat status=%0d vertex=%0d", got.status, got.vertex));
         end else begin
            want = expected_beats.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.vertex !== want.vertex)
               report($sformatf("vertex %0d, want %0d", got.vertex, want.vertex));
            if (got.parent !== want.parent)
               report($sformatf("vertex %0d parent %0d, want %0d",
                                want.vertex, got.parent, want.parent));
            if (got.disc !== want.disc)
               report($sformatf("vertex %0d discovery %0d, want %0d",
                                want.vertex, got.disc, want.disc));
            if (got.fin !== want.fin)
               report($sformatf("vertex %0d finish %0d, want %0d",
                                want.vertex, got.fin, want.fin));
            if (got.last !== want.last)
               report($sformatf("vertex %0d last %0b, want %0b",
                                want.vertex, got.last, want.last));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_opcode;
   logic [3:0]        req_edge_from;
   logic [3:0]        req_edge_to;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [3:0]        rsp_vertex;
   logic signed [4:0] rsp_parent_vertex;
   logic [5:0]        rsp_discovery_time;
   logic [5:0]        rsp_finish_time;
   logic              rsp_last;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [1:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   search_scoreboard sb;
   int               stall_cycles;
   int               items_sent;
   int               runs_sent;

   dfs_timestamp_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_vertex         (rsp_vertex),
      .rsp_parent_vertex  (rsp_parent_vertex),
      .rsp_discovery_time (rsp_discovery_time),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result beats go straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result({rsp_status, rsp_vertex, rsp_parent_vertex,
                          rsp_discovery_time, rsp_finish_time, rsp_last});
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // mostly back-to-back, sometimes short, rarely long gaps
   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task send_item(logic op, logic [3:0] from, logic [3:0] to);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_edge_from <= from;
      req_edge_to   <= to;
      do @(posedge clock); while (busy);
      sb.note_item(op, from, to);
      items_sent++;
      if (op == dfs_pkg::OP_RUN) runs_sent++;
   endtask

   task send_edge(logic [3:0] from, logic [3:0] to);
      send_item(dfs_pkg::OP_ADD_EDGE, from, to);
   endtask

   task send_run();
      send_item(dfs_pkg::OP_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   // let every expected beat arrive, then let a result-less run finish
   task drain();
      start <= 1'b0;
      while (sb.expected_beats.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task write_vertex_count(logic [4:0] value);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= 2'(dfs_pkg::REG_VERTEX_COUNT * 4);
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.vcount = int'(value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[4:0] !== value)
         sb.report($sformatf("vertex_count reads %0d, wrote %0d", prdata[4:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one random phase: a count, a burst of edges, then searches
   task random_phase(int n_edges);
      int cnt;
      int p;
      p = $urandom_range(0, 19);
      if (p == 0) cnt = 0;
      else if (p == 1) cnt = $urandom_range(17, 31);
      else if (p < 5) cnt = 16;
      else cnt = $urandom_range(1, 16);
      write_vertex_count(5'(cnt));
      for (int i = 0; i < n_edges; i++) begin
         if (cnt > 0 && $urandom_range(0, 9) < 8)
            send_edge(4'($urandom_range(0, (cnt > 16 ? 16 : cnt) - 1)),
                      4'($urandom_range(0, (cnt > 16 ? 16 : cnt) - 1)));
         else
            send_edge(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
      send_run();
      if ($urandom_range(0, 3) == 0) send_run();
   endtask

   initial begin
      sb            = new();
      stall_cycles  = 0;
      items_sent    = 0;
      runs_sent     = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = dfs_pkg::OP_ADD_EDGE;
      req_edge_from = '0;
      req_edge_to   = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, chains, self loop, back edge, top vertex
      send_run();
      send_edge(0, 1);
      send_edge(1, 2);
      send_edge(0, 15);
      send_edge(15, 0);
      send_edge(2, 2);
      send_edge(2, 0);
      send_run();
      // small count: out-of-range endpoints, older edges past the count ignored by the walk
      write_vertex_count(5);
      send_edge(5, 0);
      send_edge(0, 5);
      send_edge(4, 4);
      send_edge(3, 1);
      send_run();
      // single vertex
      write_vertex_count(1);
      send_edge(0, 0);
      send_edge(1, 0);
      send_run();
      // zero count: all edges rejected, run emits nothing
      write_vertex_count(0);
      send_edge(0, 0);
      send_run();
      // count above the limit behaves as the limit
      write_vertex_count(31);
      send_edge(15, 14);
      send_run();

      // random phases until about 230 items, table fills along the way
      while (items_sent < 230) random_phase($urandom_range(2, 12));
      // full table at full size, including rejections
      write_vertex_count(16);
      while (sb.stored < EMAX)
         send_edge(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      send_edge(7, 9);
      send_run();

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d items (%0d searches), %0d result beats checked, %0d edges stored",
               items_sent, runs_sent, sb.checked, sb.stored);
      if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d beats never seen", sb.errors, sb.expected_beats.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
